// ----- rtl/address_range_owner_map_assert.svh -----
// assertion macros for the address range owner map
`ifndef ADDRESS_RANGE_OWNER_MAP_ASSERT_SVH
`define ADDRESS_RANGE_OWNER_MAP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define AROM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("address range owner map check failed");

// next-cycle implication, sampled on clk, off during reset
`define AROM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("address range owner map check failed");

`endif

// ----- rtl/arom_pkg.sv -----
`timescale 1ns / 1ps

package arom_pkg;

    localparam int MAX_AREAS_DEF = 64;

    localparam logic [7:0] TAG_FREE        = 8'd253;
    localparam logic [7:0] TAG_NOT_IN_FILE = 8'd254;
    localparam logic [7:0] TAG_END         = 8'd252;

    localparam logic signed [31:0] ADDR_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ADDR_MAX = 32'sh7FFF_FFFF;

    localparam logic CMD_CHANGE = 1'b0;
    localparam logic CMD_CHECK  = 1'b1;

    // write data source
    typedef enum logic [2:0] {
        WR_SHIFT,
        WR_START,
        WR_END,
        WR_RETAG,
        WR_INIT0,
        WR_INIT1
    } wr_sel_t;

    // previous-entry tag update
    typedef enum logic [1:0] {
        PREV_HOLD,
        PREV_RD,
        PREV_CUR,
        PREV_TO
    } prev_sel_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_FREE,
        RES_RD
    } res_sel_t;

    typedef struct packed {
        logic      load_in;
        logic      rd_en;
        logic      we;
        wr_sel_t   wr_sel;
        logic      cur_load;
        prev_sel_t prev_sel;
        logic      out_load;
        res_sel_t  res_sel;
        logic      full;
    } dp_cmd_t;

    typedef struct packed {
        logic is_check;
        logic lt_start;
        logic eq_start;
        logic le_start;
        logic lt_end;
        logic gt_end;
        logic t_to;
        logic t_stop;
        logic prev_from;
        logic prev_to;
        logic cur_from;
    } dp_stat_t;

endpackage

// ----- rtl/arom_dpath.sv -----
`timescale 1ns / 1ps

module arom_dpath #(
    parameter int MAX_AREAS = arom_pkg::MAX_AREAS_DEF,
    localparam int AW = $clog2(MAX_AREAS)
) (
    input  logic                clk,
    input  logic                command,
    input  logic signed [31:0]  start_addr,
    input  logic signed [31:0]  end_addr,
    input  logic [7:0]          from_tag,
    input  logic [7:0]          to_tag,
    input  logic [7:0]          query_tag,
    input  arom_pkg::dp_cmd_t   cmd,
    input  logic [AW-1:0]       rd_addr,
    input  logic [AW-1:0]       wr_addr,
    output arom_pkg::dp_stat_t  stat,
    output logic [7:0]          result_tag,
    output logic                table_full
);

    logic signed [31:0] bnd_mem [MAX_AREAS];
    logic [7:0]         tag_mem [MAX_AREAS];

    logic               cmd_reg;
    logic signed [31:0] start_reg;
    logic signed [31:0] end_reg;
    logic [7:0]         from_reg;
    logic [7:0]         to_reg;
    logic [7:0]         query_reg;

    logic signed [31:0] rd_b_reg;
    logic [7:0]         rd_t_reg;
    logic signed [31:0] cur_b_reg;
    logic [7:0]         cur_t_reg;
    logic [7:0]         prev_reg;
    logic [7:0]         res_reg;
    logic               full_reg;

    logic signed [31:0] wr_b;
    logic [7:0]         wr_t;

    always_comb
    begin
        case (cmd.wr_sel)
            arom_pkg::WR_SHIFT:
            begin
                wr_b = rd_b_reg;
                wr_t = rd_t_reg;
            end
            arom_pkg::WR_START:
            begin
                wr_b = start_reg;
                wr_t = prev_reg;
            end
            arom_pkg::WR_END:
            begin
                wr_b = end_reg;
                wr_t = cur_t_reg;
            end
            arom_pkg::WR_RETAG:
            begin
                wr_b = cur_b_reg;
                wr_t = to_reg;
            end
            arom_pkg::WR_INIT0:
            begin
                wr_b = arom_pkg::ADDR_MIN;
                wr_t = arom_pkg::TAG_NOT_IN_FILE;
            end
            default:
            begin
                wr_b = arom_pkg::ADDR_MAX;
                wr_t = arom_pkg::TAG_END;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg   <= command;
            start_reg <= start_addr;
            end_reg   <= end_addr;
            from_reg  <= from_tag;
            to_reg    <= to_tag;
            query_reg <= query_tag;
        end
        if (cmd.we)
        begin
            bnd_mem[wr_addr] <= wr_b;
            tag_mem[wr_addr] <= wr_t;
        end
        if (cmd.rd_en)
        begin
            rd_b_reg <= bnd_mem[rd_addr];
            rd_t_reg <= tag_mem[rd_addr];
        end
        if (cmd.cur_load)
        begin
            cur_b_reg <= rd_b_reg;
            cur_t_reg <= rd_t_reg;
        end
        case (cmd.prev_sel)
            arom_pkg::PREV_RD:  prev_reg <= rd_t_reg;
            arom_pkg::PREV_CUR: prev_reg <= cur_t_reg;
            arom_pkg::PREV_TO:  prev_reg <= to_reg;
            default:            prev_reg <= prev_reg;
        endcase
        if (cmd.out_load)
        begin
            case (cmd.res_sel)
                arom_pkg::RES_FREE: res_reg <= arom_pkg::TAG_FREE;
                arom_pkg::RES_RD:   res_reg <= rd_t_reg;
                default:            res_reg <= 8'd0;
            endcase
            full_reg <= cmd.full;
        end
    end

    always_comb
    begin
        stat.is_check  = (cmd_reg == arom_pkg::CMD_CHECK);
        stat.lt_start  = rd_b_reg < start_reg;
        stat.eq_start  = rd_b_reg == start_reg;
        stat.le_start  = rd_b_reg <= start_reg;
        stat.lt_end    = rd_b_reg < end_reg;
        stat.gt_end    = rd_b_reg > end_reg;
        stat.t_to      = rd_t_reg == to_reg;
        stat.t_stop    = (rd_t_reg != arom_pkg::TAG_FREE) && (rd_t_reg != query_reg);
        stat.prev_from = prev_reg == from_reg;
        stat.prev_to   = prev_reg == to_reg;
        stat.cur_from  = cur_t_reg == from_reg;
    end

    assign result_tag = res_reg;
    assign table_full = full_reg;

endmodule

// ----- rtl/arom_ctrl.sv -----
`timescale 1ns / 1ps

module arom_ctrl #(
    parameter int MAX_AREAS = arom_pkg::MAX_AREAS_DEF,
    localparam int AW = $clog2(MAX_AREAS),
    localparam int IW = $clog2(MAX_AREAS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  arom_pkg::dp_stat_t stat,
    output arom_pkg::dp_cmd_t  cmd,
    output logic [AW-1:0]      rd_addr,
    output logic [AW-1:0]      wr_addr
);

    typedef enum logic [4:0] {
        S_INIT0, S_INIT1, S_IDLE, S_DISPATCH,
        S_CSCAN_RD, S_CSCAN_CMP,
        S_LOOP_RD, S_LOOP_A, S_LOOP_B, S_LOOP_T,
        S_LMERGE, S_RMERGE_RD, S_RMERGE_CMP, S_NEXT,
        S_INS_RD, S_INS_WR, S_INS_PUT,
        S_REM_RD, S_REM_WR,
        S_K1_RD, S_K1_CMP, S_K2_RD, S_K2_CMP,
        S_FIN
    } state_t;

    state_t               state_reg, state_next;
    state_t               ret_reg, ret_next;
    logic [IW-1:0]        i_reg, i_next;
    logic [IW-1:0]        k_reg, k_next;
    logic [IW-1:0]        p_reg, p_next;
    logic [IW-1:0]        used_reg, used_next;
    logic                 ins_end_reg, ins_end_next;
    arom_pkg::res_sel_t   res_reg, res_next;
    logic                 full_reg, full_next;
    logic                 out_valid_reg, out_valid_next;

    logic [IW-1:0] i_inc;
    logic [IW-1:0] k_inc;
    logic [IW-1:0] k_dec;
    logic          used_full;

    assign i_inc     = i_reg + 1'b1;
    assign k_inc     = k_reg + 1'b1;
    assign k_dec     = k_reg - 1'b1;
    assign used_full = used_reg >= IW'(MAX_AREAS);

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        used_next      = used_reg;
        ins_end_next   = ins_end_reg;
        res_next       = res_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        rd_addr        = i_reg[AW-1:0];
        wr_addr        = i_reg[AW-1:0];
        in_ready       = 1'b0;

        unique case (state_reg)
            S_INIT0:
            begin
                cmd.we     = 1'b1;
                cmd.wr_sel = arom_pkg::WR_INIT0;
                wr_addr    = AW'(0);
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                cmd.we     = 1'b1;
                cmd.wr_sel = arom_pkg::WR_INIT1;
                wr_addr    = AW'(1);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_check)
                begin
                    i_next     = IW'(1);
                    state_next = S_K1_RD;
                end
                else
                begin
                    i_next     = '0;
                    state_next = S_CSCAN_RD;
                end
            end
            // change: find first entry at or above start
            S_CSCAN_RD:
            begin
                if (i_reg >= used_reg)
                begin
                    res_next   = arom_pkg::RES_ZERO;
                    full_next  = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_CSCAN_CMP;
                end
            end
            S_CSCAN_CMP:
            begin
                if (stat.lt_start)
                begin
                    cmd.prev_sel = arom_pkg::PREV_RD;
                    i_next       = i_inc;
                    state_next   = S_CSCAN_RD;
                end
                else if (!stat.eq_start && i_reg != '0 && stat.prev_from)
                begin
                    if (used_full)
                    begin
                        res_next   = arom_pkg::RES_ZERO;
                        full_next  = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        p_next       = i_reg;
                        k_next       = used_reg;
                        ins_end_next = 1'b0;
                        ret_next     = S_LOOP_RD;
                        state_next   = S_INS_RD;
                    end
                end
                else
                begin
                    state_next = S_LOOP_RD;
                end
            end
            S_LOOP_RD:
            begin
                if (i_reg >= used_reg)
                begin
                    res_next   = arom_pkg::RES_ZERO;
                    full_next  = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_LOOP_A;
                end
            end
            S_LOOP_A:
            begin
                if (!stat.lt_end)
                begin
                    res_next   = arom_pkg::RES_ZERO;
                    full_next  = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.cur_load = 1'b1;
                    if (i_inc < used_reg)
                    begin
                        cmd.rd_en  = 1'b1;
                        rd_addr    = i_inc[AW-1:0];
                        state_next = S_LOOP_B;
                    end
                    else
                    begin
                        state_next = S_LOOP_T;
                    end
                end
            end
            S_LOOP_B:
            begin
                if (stat.gt_end)
                begin
                    if (used_full)
                    begin
                        res_next   = arom_pkg::RES_ZERO;
                        full_next  = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        p_next       = i_inc;
                        k_next       = used_reg;
                        ins_end_next = 1'b1;
                        ret_next     = S_LOOP_T;
                        state_next   = S_INS_RD;
                    end
                end
                else
                begin
                    state_next = S_LOOP_T;
                end
            end
            S_LOOP_T:
            begin
                if (stat.cur_from)
                begin
                    cmd.we     = 1'b1;
                    cmd.wr_sel = arom_pkg::WR_RETAG;
                    state_next = S_LMERGE;
                end
                else
                begin
                    cmd.prev_sel = arom_pkg::PREV_CUR;
                    i_next       = i_inc;
                    state_next   = S_LOOP_RD;
                end
            end
            // merge with left neighbor: drop entry i, step back
            S_LMERGE:
            begin
                if (i_reg != '0 && stat.prev_to)
                begin
                    k_next     = i_reg;
                    i_next     = i_reg - 1'b1;
                    ret_next   = S_RMERGE_RD;
                    state_next = S_REM_RD;
                end
                else
                begin
                    state_next = S_RMERGE_RD;
                end
            end
            S_RMERGE_RD:
            begin
                if (i_inc < used_reg)
                begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = i_inc[AW-1:0];
                    state_next = S_RMERGE_CMP;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_RMERGE_CMP:
            begin
                if (stat.t_to)
                begin
                    k_next     = i_inc;
                    ret_next   = S_NEXT;
                    state_next = S_REM_RD;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                cmd.prev_sel = arom_pkg::PREV_TO;
                i_next       = i_inc;
                state_next   = S_LOOP_RD;
            end
            // insert: shift entries up one place, top down
            S_INS_RD:
            begin
                if (k_reg == p_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = k_dec[AW-1:0];
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                cmd.we     = 1'b1;
                cmd.wr_sel = arom_pkg::WR_SHIFT;
                wr_addr    = k_reg[AW-1:0];
                k_next     = k_dec;
                state_next = S_INS_RD;
            end
            S_INS_PUT:
            begin
                cmd.we     = 1'b1;
                cmd.wr_sel = ins_end_reg ? arom_pkg::WR_END : arom_pkg::WR_START;
                wr_addr    = p_reg[AW-1:0];
                used_next  = used_reg + 1'b1;
                state_next = ret_reg;
            end
            // remove: shift entries down one place, bottom up
            S_REM_RD:
            begin
                if (k_inc >= used_reg)
                begin
                    used_next  = used_reg - 1'b1;
                    state_next = ret_reg;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = k_inc[AW-1:0];
                    state_next = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                cmd.we     = 1'b1;
                cmd.wr_sel = arom_pkg::WR_SHIFT;
                wr_addr    = k_reg[AW-1:0];
                k_next     = k_inc;
                state_next = S_REM_RD;
            end
            // check: locate entry holding start
            S_K1_RD:
            begin
                if (i_reg >= used_reg)
                begin
                    i_next     = i_reg - 1'b1;
                    state_next = S_K2_RD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_K1_CMP;
                end
            end
            S_K1_CMP:
            begin
                if (stat.le_start)
                begin
                    i_next     = i_inc;
                    state_next = S_K1_RD;
                end
                else
                begin
                    i_next     = i_reg - 1'b1;
                    state_next = S_K2_RD;
                end
            end
            S_K2_RD:
            begin
                if (i_reg >= used_reg)
                begin
                    res_next   = arom_pkg::RES_FREE;
                    full_next  = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_K2_CMP;
                end
            end
            S_K2_CMP:
            begin
                if (!stat.lt_end)
                begin
                    res_next   = arom_pkg::RES_FREE;
                    full_next  = 1'b0;
                    state_next = S_FIN;
                end
                else if (stat.t_stop)
                begin
                    res_next   = arom_pkg::RES_RD;
                    full_next  = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_K2_RD;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.res_sel    = res_reg;
                    cmd.full       = full_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT0;
            ret_reg       <= S_IDLE;
            i_reg         <= '0;
            k_reg         <= '0;
            p_reg         <= '0;
            used_reg      <= IW'(2);
            ins_end_reg   <= 1'b0;
            res_reg       <= arom_pkg::RES_ZERO;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            p_reg         <= p_next;
            used_reg      <= used_next;
            ins_end_reg   <= ins_end_next;
            res_reg       <= res_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/address_range_owner_map.sv -----
`timescale 1ns / 1ps
// change: walks the entries below start, then each entry in the range (retagging those that
// match from_tag), plus the entries moved by a split or merge
// check: walks the entries up to start, then scans on until end or a stopping tag
// throughput: one request at a time, every table access goes through the one table read and write port
// a finished result sits in an output register so the next request is taken meanwhile
// reset: table holds the two sentinels, written to memory in S_INIT0 and S_INIT1 while in_ready is low

module address_range_owner_map #(
    parameter int MAX_AREAS = arom_pkg::MAX_AREAS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic signed [31:0] start_addr,
    input  logic signed [31:0] end_addr,
    input  logic [7:0]         from_tag,
    input  logic [7:0]         to_tag,
    input  logic [7:0]         query_tag,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         result_tag,
    output logic               table_full
);

    localparam int AW = $clog2(MAX_AREAS);

    // controller to datapath commands and status flags
    arom_pkg::dp_cmd_t  cmd;
    arom_pkg::dp_stat_t stat;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;

    // sequencer: table walk, split/merge shifts, result handoff
    arom_ctrl #(
        .MAX_AREAS (MAX_AREAS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr)
    );

    // boundary/tag memory, request operands, compares, result register
    arom_dpath #(
        .MAX_AREAS (MAX_AREAS)
    ) u_dpath (
        .clk        (clk),
        .command    (command),
        .start_addr (start_addr),
        .end_addr   (end_addr),
        .from_tag   (from_tag),
        .to_tag     (to_tag),
        .query_tag  (query_tag),
        .cmd        (cmd),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .stat       (stat),
        .result_tag (result_tag),
        .table_full (table_full)
    );

endmodule

// ----- rtl/arom_chk.sv -----
`timescale 1ns / 1ps
`include "address_range_owner_map_assert.svh"

module arom_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] result_tag,
    input logic       table_full
);

    // held result stays put
    `AROM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_tag) && $stable(table_full))

    // one request in flight: busy right after accept
    `AROM_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // full flag only comes with a change result
    `AROM_ASSERT_NOW(a_full_zero_tag, out_valid && table_full, result_tag == 8'd0)

endmodule

bind address_range_owner_map arom_chk u_arom_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_tag (result_tag),
    .table_full (table_full)
);
